// File: rtl/vcs_pkg.sv
// Package: shared types, register indexes and reset values for the velocity command shaper.
package vcs_pkg;

	// Configuration port geometry
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Register indexes on the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_LIMIT_VX      = 3'd0,
		REG_LIMIT_WZ      = 3'd1,
		REG_STEP_VX       = 3'd2,
		REG_STEP_WZ       = 3'd3,
		REG_TIMEOUT_TICKS = 3'd4,
		REG_SIM_MODE      = 3'd5,
		REG_DEADBAND_VX   = 3'd6,
		REG_DEADBAND_WZ   = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [14:0] LimitVxRst   = 15'd1229;
	localparam logic [14:0] LimitWzRst   = 15'd4915;
	localparam logic [14:0] StepVxRst    = 15'd410;
	localparam logic [14:0] StepWzRst    = 15'd819;
	localparam logic [15:0] TimeoutRst   = 16'd20;
	localparam logic        SimModeRst   = 1'b1;
	localparam logic [14:0] DeadbandVxRst = 15'd41;
	localparam logic [14:0] DeadbandWzRst = 15'd205;

	// Input item kinds
	typedef enum logic {
		KIND_CMD  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// Platform mode codes
	typedef enum logic [2:0] {
		MODE_INIT       = 3'd0,
		MODE_DISABLED   = 3'd1,
		MODE_READY      = 3'd2,
		MODE_EXECUTING  = 3'd3,
		MODE_RECOVERING = 3'd4,
		MODE_SAFE_STOP  = 3'd5,
		MODE_FAULT      = 3'd6
	} mode_t;

	// Configuration register set
	typedef struct packed {
		logic [14:0] limit_vx;
		logic [14:0] limit_wz;
		logic [14:0] step_vx;
		logic [14:0] step_wz;
		logic [15:0] timeout_ticks;
		logic        sim_mode;
		logic [14:0] deadband_vx;
		logic [14:0] deadband_wz;
	} cfg_t;

	// Status snapshot handed from the core to the output register
	typedef struct packed {
		mode_t              mode;
		logic               is_standing;
		logic               is_moving;
		logic               is_controllable;
		logic signed [15:0] out_vx;
		logic signed [15:0] out_wz;
	} status_t;

endpackage

// File: rtl/vcs_in_if.sv
// Interface: input item channel (commands and ticks).
interface vcs_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] cmd_vx;
	logic signed [15:0] cmd_wz;

	modport source (output valid, output kind, output cmd_vx, output cmd_wz, input ready);
	modport sink   (input valid, input kind, input cmd_vx, input cmd_wz, output ready);
endinterface

// File: rtl/vcs_out_if.sv
// Interface: status result channel.
interface vcs_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic               is_standing;
	logic               is_moving;
	logic               is_controllable;
	logic signed [15:0] out_vx;
	logic signed [15:0] out_wz;

	modport source (output valid, output mode, output is_standing, output is_moving,
		output is_controllable, output out_vx, output out_wz, input ready);
	modport sink   (input valid, input mode, input is_standing, input is_moving,
		input is_controllable, input out_vx, input out_wz, output ready);
endinterface

// File: rtl/vcs_cfg_regs.sv
// Configuration register file with write-only port.
module vcs_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vcs_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [vcs_pkg::CfgDataW-1:0] cfg_wdata,
	output vcs_pkg::cfg_t                cfg
);

	vcs_pkg::cfg_t cfg_q;

	// Register writes; each register keeps only its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_vx      <= vcs_pkg::LimitVxRst;
			cfg_q.limit_wz      <= vcs_pkg::LimitWzRst;
			cfg_q.step_vx       <= vcs_pkg::StepVxRst;
			cfg_q.step_wz       <= vcs_pkg::StepWzRst;
			cfg_q.timeout_ticks <= vcs_pkg::TimeoutRst;
			cfg_q.sim_mode      <= vcs_pkg::SimModeRst;
			cfg_q.deadband_vx   <= vcs_pkg::DeadbandVxRst;
			cfg_q.deadband_wz   <= vcs_pkg::DeadbandWzRst;
		end else if (cfg_we) begin
			case (vcs_pkg::reg_idx_t'(cfg_idx))
				vcs_pkg::REG_LIMIT_VX:      cfg_q.limit_vx      <= cfg_wdata[14:0];
				vcs_pkg::REG_LIMIT_WZ:      cfg_q.limit_wz      <= cfg_wdata[14:0];
				vcs_pkg::REG_STEP_VX:       cfg_q.step_vx       <= cfg_wdata[14:0];
				vcs_pkg::REG_STEP_WZ:       cfg_q.step_wz       <= cfg_wdata[14:0];
				vcs_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata[15:0];
				vcs_pkg::REG_SIM_MODE:      cfg_q.sim_mode      <= cfg_wdata[0];
				vcs_pkg::REG_DEADBAND_VX:   cfg_q.deadband_vx   <= cfg_wdata[14:0];
				vcs_pkg::REG_DEADBAND_WZ:   cfg_q.deadband_wz   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/vcs_axis_shaper.sv
// Single-axis shaping: clamp to limit, slew-limit against current value, deadband.
module vcs_axis_shaper (
	input  logic signed [15:0] cur,
	input  logic signed [15:0] cmd,
	input  logic        [14:0] lim,
	input  logic        [14:0] step,
	input  logic        [14:0] db,
	output logic signed [15:0] vel,
	output logic               moving
);

	logic signed [17:0] lim_p, lim_n, cmd_x, target, lo, hi, slewed, mag, db_x;

	// Clamp the request to +/- limit
	always_comb begin
		lim_p = $signed({3'b000, lim});
		lim_n = -lim_p;
		cmd_x = 18'(cmd);
		if (cmd_x > lim_p) begin
			target = lim_p;
		end else if (cmd_x < lim_n) begin
			target = lim_n;
		end else begin
			target = cmd_x;
		end
	end

	// Slew window around the current value; result always fits 16 bits
	always_comb begin
		lo = 18'(cur) - $signed({3'b000, step});
		hi = 18'(cur) + $signed({3'b000, step});
		if (target < lo) begin
			slewed = lo;
		end else if (target > hi) begin
			slewed = hi;
		end else begin
			slewed = target;
		end
	end

	// Deadband: below it the axis is zero; equal is kept but not moving
	always_comb begin
		mag  = (slewed < 18'sd0) ? -slewed : slewed;
		db_x = $signed({3'b000, db});
		vel    = (mag < db_x) ? 16'sd0 : slewed[15:0];
		moving = (mag > db_x);
	end

endmodule

// File: rtl/vcs_core.sv
// Shaper state: velocities, mode sequence, flags and idle tick counter.
module vcs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_fire,
	input  logic               item_kind,
	input  logic signed [15:0] cmd_vx,
	input  logic signed [15:0] cmd_wz,
	input  vcs_pkg::cfg_t      cfg,
	output vcs_pkg::status_t   status_nxt
);

	logic signed [15:0] vel_x_q, vel_z_q;
	vcs_pkg::mode_t     mode_q;
	logic               stand_q, ctrl_q, moving_q;
	logic [15:0]        idle_q;

	logic signed [15:0] vel_x_d, vel_z_d, shp_vx, shp_wz;
	vcs_pkg::mode_t     mode_d, mode_to;
	logic               stand_d, ctrl_d, moving_d, moving_to;
	logic [15:0]        idle_d, idle_inc;
	logic               mov_x, mov_z, cmd_ok, timeout;

	// Per-axis shaping of the command
	vcs_axis_shaper u_axis_x (
		.cur    (vel_x_q),
		.cmd    (cmd_vx),
		.lim    (cfg.limit_vx),
		.step   (cfg.step_vx),
		.db     (cfg.deadband_vx),
		.vel    (shp_vx),
		.moving (mov_x)
	);

	vcs_axis_shaper u_axis_z (
		.cur    (vel_z_q),
		.cmd    (cmd_wz),
		.lim    (cfg.limit_wz),
		.step   (cfg.step_wz),
		.db     (cfg.deadband_wz),
		.vel    (shp_wz),
		.moving (mov_z)
	);

	// Tick side: saturating idle count and timeout
	always_comb begin
		idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		timeout  = ctrl_q && stand_q && (idle_inc > cfg.timeout_ticks);
		cmd_ok   = ctrl_q && stand_q;
		// Timeout drops executing back to ready
		if (timeout && mode_q == vcs_pkg::MODE_EXECUTING) begin
			mode_to   = vcs_pkg::MODE_READY;
			moving_to = 1'b0;
		end else begin
			mode_to   = mode_q;
			moving_to = moving_q;
		end
	end

	// Next state for the accepted item
	always_comb begin
		vel_x_d  = vel_x_q;
		vel_z_d  = vel_z_q;
		mode_d   = mode_q;
		stand_d  = stand_q;
		ctrl_d   = ctrl_q;
		moving_d = moving_q;
		idle_d   = idle_q;
		if (item_kind == vcs_pkg::KIND_TICK) begin
			idle_d   = idle_inc;
			moving_d = moving_to;
			mode_d   = mode_to;
			if (timeout) begin
				vel_x_d = '0;
				vel_z_d = '0;
			end
			case (mode_to)
				vcs_pkg::MODE_INIT: begin
					mode_d = vcs_pkg::MODE_DISABLED;
				end
				vcs_pkg::MODE_DISABLED: begin
					if (cfg.sim_mode) begin
						mode_d  = vcs_pkg::MODE_READY;
						stand_d = 1'b1;
						ctrl_d  = 1'b1;
					end
				end
				vcs_pkg::MODE_READY: begin
					if (cfg.sim_mode) begin
						stand_d = 1'b1;
						ctrl_d  = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd_ok) begin
			idle_d   = '0;
			vel_x_d  = shp_vx;
			vel_z_d  = shp_wz;
			moving_d = mov_x || mov_z;
			if (mov_x || mov_z) begin
				mode_d = vcs_pkg::MODE_EXECUTING;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_x_q  <= '0;
			vel_z_q  <= '0;
			mode_q   <= vcs_pkg::MODE_INIT;
			stand_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			moving_q <= 1'b0;
			idle_q   <= '0;
		end else if (item_fire) begin
			vel_x_q  <= vel_x_d;
			vel_z_q  <= vel_z_d;
			mode_q   <= mode_d;
			stand_q  <= stand_d;
			ctrl_q   <= ctrl_d;
			moving_q <= moving_d;
			idle_q   <= idle_d;
		end
	end

	// Status after this item, taken by the output register on a tick
	always_comb begin
		status_nxt.mode            = mode_d;
		status_nxt.is_standing     = stand_d;
		status_nxt.is_moving       = moving_d;
		status_nxt.is_controllable = ctrl_d;
		status_nxt.out_vx          = vel_x_d;
		status_nxt.out_wz          = vel_z_d;
	end

	// Moving is only ever set together with executing
	a_moving_exec: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> mode_q == vcs_pkg::MODE_EXECUTING)
		else $error("moving flag set outside executing mode");

	// Standing and controllable are raised together and never dropped
	a_flags_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(stand_q == ctrl_q) and ($past(ctrl_q) |-> ctrl_q))
		else $error("standing and controllable flags diverged or dropped");

	// A non-zero velocity needs an accepted command, so the platform must be controllable
	a_vel_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(vel_x_q != 16'sd0 || vel_z_q != 16'sd0) |-> ctrl_q)
		else $error("velocity set while not controllable");

endmodule

// File: rtl/velocity_command_shaper.sv
// Top level: velocity command shaper with config registers, state core and status register.
//
//  channel   | dir | beat contents                       | beat count
//  ----------+-----+-------------------------------------+---------------------------
//  cmd_in    | in  | kind, cmd_vx, cmd_wz                | one per command or tick
//  sts_out   | out | mode, flags, out_vx, out_wz         | one per accepted tick
//  cfg_*     | in  | cfg_idx, cfg_wdata on cfg_we        | one per register write
//
// One item per cycle while cmd_in is not stalled: the shaping and mode update are
// combinational between the state registers and the status register.
// A tick's status appears on sts_out the cycle after the tick is accepted.
// cmd_in stalls only while a status beat is held and sts_out.ready is low.
// Reset (arst_n low) clears state to init mode and loads register defaults.
module velocity_command_shaper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vcs_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [vcs_pkg::CfgDataW-1:0] cfg_wdata,
	vcs_in_if.sink                       cmd_in,
	vcs_out_if.source                    sts_out
);

	vcs_pkg::cfg_t    cfg;
	vcs_pkg::status_t status_nxt;
	vcs_pkg::status_t sts_q;
	logic             sts_vld_q;
	logic             in_fire, tick_fire;

	vcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vcs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_fire  (in_fire),
		.item_kind  (cmd_in.kind),
		.cmd_vx     (cmd_in.cmd_vx),
		.cmd_wz     (cmd_in.cmd_wz),
		.cfg        (cfg),
		.status_nxt (status_nxt)
	);

	// Input handshake: free whenever the status slot is empty or draining
	assign cmd_in.ready = !sts_vld_q || sts_out.ready;
	assign in_fire      = cmd_in.valid && cmd_in.ready;
	assign tick_fire    = in_fire && (cmd_in.kind == vcs_pkg::KIND_TICK);

	// Status output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts_vld_q <= 1'b0;
		end else if (tick_fire) begin
			sts_vld_q <= 1'b1;
		end else if (sts_out.ready) begin
			sts_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			sts_q <= status_nxt;
		end
	end

	assign sts_out.valid           = sts_vld_q;
	assign sts_out.mode            = sts_q.mode;
	assign sts_out.is_standing     = sts_q.is_standing;
	assign sts_out.is_moving       = sts_q.is_moving;
	assign sts_out.is_controllable = sts_q.is_controllable;
	assign sts_out.out_vx          = sts_q.out_vx;
	assign sts_out.out_wz          = sts_q.out_wz;

	// Every accepted tick leaves a status beat pending in the next cycle
	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> sts_vld_q)
		else $error("accepted tick produced no status beat");

	// A command beat never creates a status beat
	a_cmd_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd_in.kind == vcs_pkg::KIND_CMD && (!sts_vld_q || sts_out.ready))
		|=> !sts_vld_q)
		else $error("command beat produced a status beat");

	// A held status beat is never overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(sts_vld_q && !sts_out.ready) |-> !in_fire)
		else $error("input accepted while status beat stalled");

endmodule
